[sv/binary_trie_max_xor_assert.svh]
// Assertion macros for the binary trie max-XOR block.
// Depends on signals named clock and reset in the module that includes it.
`ifndef BINARY_TRIE_MAX_XOR_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define BTMX_ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("binary trie max-xor check failed");

// A condition that must hold in the same cycle as its trigger.
`define BTMX_ASSERT_IMPLIES(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("binary trie max-xor check failed");

// A condition that must hold in the cycle after its trigger.
`define BTMX_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("binary trie max-xor check failed");

`endif

[sv/btmx_pkg.sv]
// Shared types and constants for the binary trie max-XOR block.
// Used by btmx_node_ram and binary_trie_max_xor; depends on nothing.
package btmx_pkg;

   // Trie geometry.
   localparam int KEY_BITS   = 30;
   localparam int NODES      = 65536;
   localparam int NODE_BITS  = $clog2(NODES);
   localparam int COUNT_BITS = NODE_BITS + 1;
   localparam int LEVEL_BITS = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

   // Operation codes.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Input word.
   typedef struct packed {
      logic [1:0]          op;
      logic [KEY_BITS-1:0] key;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [KEY_BITS-1:0] max_xor;
      logic [KEY_BITS-1:0] best_key;
      logic [1:0]          status;
   } rsp_type;

   // One trie node: child indices for bit 1 and bit 0, zero means no child.
   typedef struct packed {
      logic [NODE_BITS-1:0] child1;
      logic [NODE_BITS-1:0] child0;
   } node_type;

   // Access request from the walker to the node memory.
   typedef struct packed {
      logic                 we;
      logic [NODE_BITS-1:0] waddr;
      node_type             wdata;
      logic [NODE_BITS-1:0] raddr;
   } ram_req_type;

endpackage

[sv/btmx_node_ram.sv]
// Node memory of the trie: one write port and one registered read port.
// Depends on btmx_pkg for the node and request types.
module btmx_node_ram (
   input  logic                   clock,
   input  btmx_pkg::ram_req_type  ram_req,
   output btmx_pkg::node_type     rd_data
);

   btmx_pkg::node_type mem [btmx_pkg::NODES];
   btmx_pkg::node_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ram_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/binary_trie_max_xor.sv]
// Binary trie maximum-XOR engine: keeps a trie of 30-bit keys in a 65536-node
// memory and answers insert, query and clear words, one result word for each.
// An insert or a query walks one trie level per cycle, most significant key
// bit first; the walk is bound by the single dependent node read per level
// from the registered node memory. Clear, the unused op code, a query on an
// empty trie and an insert refused for a full pool skip the walk and go
// straight to the finishing state. The root node lives in a register, so
// reset and clear take effect at once and need no pass over the memory.
// One word is worked on at a time; a finished result sits in the output
// register while the next word is accepted.
// Depends on btmx_pkg, btmx_node_ram and binary_trie_max_xor_assert.svh.
`include "binary_trie_max_xor_assert.svh"

module binary_trie_max_xor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  btmx_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output btmx_pkg::rsp_type rsp_word
);

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_type;

   localparam logic [btmx_pkg::COUNT_BITS-1:0] FULL_LIMIT =
      btmx_pkg::COUNT_BITS'(btmx_pkg::NODES - btmx_pkg::KEY_BITS);
   localparam logic [btmx_pkg::LEVEL_BITS-1:0] TOP_LEVEL =
      btmx_pkg::LEVEL_BITS'(btmx_pkg::KEY_BITS - 1);

   state_type                          state_ff;
   logic                               is_query_ff;
   logic [btmx_pkg::KEY_BITS-1:0]      key_ff;
   logic [btmx_pkg::LEVEL_BITS-1:0]    level_ff;
   logic [btmx_pkg::NODE_BITS-1:0]     cur_ff;
   logic                               alloc_ff;
   logic [btmx_pkg::KEY_BITS-1:0]      found_ff;
   btmx_pkg::node_type                 root_ff;
   logic [btmx_pkg::COUNT_BITS-1:0]    node_count_ff;
   logic                               has_keys_ff;
   btmx_pkg::rsp_type                  res_ff;
   logic                               rsp_valid_ff;
   btmx_pkg::rsp_type                  rsp_word_ff;

   btmx_pkg::ram_req_type              ram_req;
   btmx_pkg::node_type                 ram_rdata;
   btmx_pkg::node_type                 entry;
   btmx_pkg::node_type                 upd_entry;
   logic                               key_bit;
   logic                               want;
   logic [btmx_pkg::NODE_BITS-1:0]     want_child;
   logic                               side;
   logic [btmx_pkg::NODE_BITS-1:0]     side_child;
   logic                               missing;
   logic [btmx_pkg::NODE_BITS-1:0]     next_node;
   logic                               write_node;
   logic [btmx_pkg::KEY_BITS-1:0]      found_in;
   logic                               out_free;

   btmx_node_ram u_node_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rdata)
   );

   // Current node: a freshly allocated node is known empty, the root is in a
   // register, every other node comes from the read issued last cycle.
   always_comb begin
      if (alloc_ff) begin
         entry = '0;
      end else if (cur_ff == '0) begin
         entry = root_ff;
      end else begin
         entry = ram_rdata;
      end
   end

   // Choose the branch for this level. A query prefers the child opposite to
   // the key bit and falls back to the other one; an insert follows the key.
   always_comb begin
      key_bit    = key_ff[level_ff];
      want       = is_query_ff ? ~key_bit : key_bit;
      want_child = want ? entry.child1 : entry.child0;
      side       = (is_query_ff && (want_child == '0)) ? ~want : want;
      side_child = side ? entry.child1 : entry.child0;
      missing    = (side_child == '0);
      write_node = (state_ff == S_WALK) && !is_query_ff && missing;
      next_node  = write_node ? node_count_ff[btmx_pkg::NODE_BITS-1:0] : side_child;
      upd_entry  = entry;
      if (side) begin
         upd_entry.child1 = node_count_ff[btmx_pkg::NODE_BITS-1:0];
      end else begin
         upd_entry.child0 = node_count_ff[btmx_pkg::NODE_BITS-1:0];
      end
      found_in = {found_ff[btmx_pkg::KEY_BITS-2:0], side};
   end

   // Memory access: link a new child into a stored node and read the next
   // node for the coming level. The written node is never the one read.
   always_comb begin
      ram_req.we    = write_node && (cur_ff != '0);
      ram_req.waddr = cur_ff;
      ram_req.wdata = upd_entry;
      ram_req.raddr = next_node;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer, trie bookkeeping and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_ff       <= '0;
         node_count_ff <= btmx_pkg::COUNT_BITS'(1);
         has_keys_ff   <= 1'b0;
         alloc_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // The finishing state reloads the output itself when it is taken.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  key_ff      <= req_word.key;
                  level_ff    <= TOP_LEVEL;
                  cur_ff      <= '0;
                  alloc_ff    <= 1'b0;
                  found_ff    <= '0;
                  is_query_ff <= (req_word.op == btmx_pkg::OP_QUERY);
                  case (req_word.op)
                     btmx_pkg::OP_INSERT: begin
                        if (node_count_ff > FULL_LIMIT) begin
                           res_ff   <= '{max_xor: '0, best_key: '0,
                                         status: btmx_pkg::ST_FULL};
                           state_ff <= S_DONE;
                        end else begin
                           res_ff   <= '0;
                           state_ff <= S_WALK;
                        end
                     end
                     btmx_pkg::OP_QUERY: begin
                        if (!has_keys_ff) begin
                           res_ff   <= '{max_xor: '0, best_key: '0,
                                         status: btmx_pkg::ST_EMPTY};
                           state_ff <= S_DONE;
                        end else begin
                           res_ff   <= '0;
                           state_ff <= S_WALK;
                        end
                     end
                     btmx_pkg::OP_CLEAR: begin
                        res_ff        <= '0;
                        state_ff      <= S_DONE;
                        root_ff       <= '0;
                        node_count_ff <= btmx_pkg::COUNT_BITS'(1);
                        has_keys_ff   <= 1'b0;
                     end
                     default: begin
                        // Unused code: result word is all zero, state untouched.
                        res_ff   <= '0;
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_WALK: begin
               cur_ff   <= next_node;
               found_ff <= found_in;
               level_ff <= level_ff - btmx_pkg::LEVEL_BITS'(1);
               if (write_node) begin
                  node_count_ff <= node_count_ff + btmx_pkg::COUNT_BITS'(1);
                  alloc_ff      <= 1'b1;
                  if (cur_ff == '0) begin
                     root_ff <= upd_entry;
                  end
               end
               if (level_ff == '0) begin
                  state_ff <= S_DONE;
                  if (is_query_ff) begin
                     res_ff.max_xor  <= key_ff ^ found_in;
                     res_ff.best_key <= found_in;
                     res_ff.status   <= btmx_pkg::ST_OK;
                  end else begin
                     has_keys_ff <= 1'b1;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_word_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The node pool never runs past its size.
   `BTMX_ASSERT_HOLDS(a_count_bound, node_count_ff <= btmx_pkg::COUNT_BITS'(btmx_pkg::NODES))
   // A write and a read in one cycle never touch the same node.
   `BTMX_ASSERT_IMPLIES(a_no_rw_clash, ram_req.we, ram_req.waddr != ram_req.raddr)
   // A walk runs through every level before it finishes.
   `BTMX_ASSERT_NEXT(a_walk_runs, (state_ff == S_WALK) && (level_ff != '0), state_ff == S_WALK)
   // A finished result reaches the output as soon as the output is free.
   `BTMX_ASSERT_NEXT(a_result_out, (state_ff == S_DONE) && out_free, rsp_valid_ff)

endmodule

[test/binary_trie_max_xor_checker.sv]
// Checker for the binary trie max-XOR block: watches both channels, predicts
// each result word with its own trie, and compares. Depends on btmx_pkg.
`timescale 1ns / 100ps

module binary_trie_max_xor_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  btmx_pkg::req_type req_word,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  btmx_pkg::rsp_type rsp_word,
   output int                fail_count,
   output int                words_waiting
);

   // Shadow trie: entry 2*n holds the bit-0 child of node n, 2*n+1 the bit-1 child.
   logic [btmx_pkg::NODE_BITS-1:0] child_link [2*btmx_pkg::NODES];
   int                             node_total;
   logic                           keys_held;
   btmx_pkg::rsp_type              pending_results [$];

   // Applies one input word to the shadow trie and returns its result word.
   task automatic apply_to_trie(input btmx_pkg::req_type w, output btmx_pkg::rsp_type r);
      int node;
      int nxt;
      int lvl;
      int side;
      r = '0;
      r.status = btmx_pkg::ST_OK;
      case (w.op)
         btmx_pkg::OP_INSERT: begin
            if (btmx_pkg::NODES - node_total < btmx_pkg::KEY_BITS) begin
               r.status = btmx_pkg::ST_FULL;
            end else begin
               node = 0;
               for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
                  side = int'(w.key[lvl]);
                  nxt = int'(child_link[2*node + side]);
                  if (nxt == 0) begin
                     nxt = node_total;
                     child_link[2*nxt] = '0;
                     child_link[2*nxt + 1] = '0;
                     node_total++;
                     child_link[2*node + side] = btmx_pkg::NODE_BITS'(nxt);
                  end
                  node = nxt;
               end
               keys_held = 1'b1;
            end
         end
         btmx_pkg::OP_QUERY: begin
            if (!keys_held) begin
               r.status = btmx_pkg::ST_EMPTY;
            end else begin
               // Take the opposite branch wherever it exists.
               node = 0;
               for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
                  side = 1 - int'(w.key[lvl]);
                  if (child_link[2*node + side] == '0) side = 1 - side;
                  node = int'(child_link[2*node + side]);
                  r.best_key[lvl] = side[0];
               end
               r.max_xor = w.key ^ r.best_key;
            end
         end
         btmx_pkg::OP_CLEAR: begin
            node_total = 1;
            child_link[0] = '0;
            child_link[1] = '0;
            keys_held = 1'b0;
         end
         default: begin
            // The spare op code leaves the trie alone.
         end
      endcase
   endtask

   // Reports one field that differs; returns the number of failures found.
   function automatic int field_off(string what, logic [btmx_pkg::KEY_BITS-1:0] want,
                                    logic [btmx_pkg::KEY_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Results are checked before the new word is predicted, since a result
   // always belongs to a word accepted at an earlier edge.
   always @(posedge clock) begin : watch
      btmx_pkg::rsp_type want;
      btmx_pkg::rsp_type fresh;
      if (reset) begin
         node_total = 1;
         child_link[0] = '0;
         child_link[1] = '0;
         keys_held = 1'b0;
         pending_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               $display("%0t: result word %h with none expected", $time, rsp_word);
            end else begin
               want = pending_results.pop_front();
               fail_count += field_off("max_xor", want.max_xor, rsp_word.max_xor);
               fail_count += field_off("best_key", want.best_key, rsp_word.best_key);
               fail_count += field_off("status", btmx_pkg::KEY_BITS'(want.status),
                                       btmx_pkg::KEY_BITS'(rsp_word.status));
            end
         end
         if (req_valid && !req_stall) begin
            apply_to_trie(req_word, fresh);
            pending_results.push_back(fresh);
         end
      end
      words_waiting = pending_results.size();
   end

endmodule

[test/tb.sv]
// Top of the binary trie max-XOR testbench: clock, reset, stimulus and verdict.
// Depends on btmx_pkg, binary_trie_max_xor and binary_trie_max_xor_checker.
`timescale 1ns / 100ps

module tb;

   localparam logic [1:0]                    OP_SPARE     = 2'd3;
   localparam logic [btmx_pkg::KEY_BITS-1:0] ALL_ONES     = '1;
   localparam int                            LIMIT_CYCLES = 2_000_000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   btmx_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   btmx_pkg::rsp_type rsp_word;

   int fail_count;
   int words_waiting;
   int idle_pct  = 0;
   int stall_pct = 0;
   int full_hits = 0;
   logic [btmx_pkg::KEY_BITS-1:0] last_key = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   binary_trie_max_xor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   binary_trie_max_xor_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .words_waiting (words_waiting)
   );

   // The result side stalls at random at the current rate.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Counts refused inserts so the growth phase can stop once the pool is spent.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_word.status == btmx_pkg::ST_FULL)
         full_hits <= full_hits + 1;
   end

   // Presents one word after a random gap and returns at the falling edge
   // after it is taken, with valid still high for the next call to settle.
   task automatic send_word(input logic [1:0] code,
                            input logic [btmx_pkg::KEY_BITS-1:0] value);
      btmx_pkg::req_type w;
      w.op = code;
      w.key = value;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Holds the input side idle until every expected result word has come.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_waiting != 0) @(negedge clock);
   endtask

   // Mostly fresh random keys, with repeats, extremes and near neighbors.
   function automatic logic [btmx_pkg::KEY_BITS-1:0] pick_key(
      logic [btmx_pkg::KEY_BITS-1:0] prior);
      case ($urandom_range(9))
         0: return prior;
         1: return '0;
         2: return ALL_ONES;
         3: return prior ^ (btmx_pkg::KEY_BITS'(1) << $urandom_range(btmx_pkg::KEY_BITS - 1));
         default: return btmx_pkg::KEY_BITS'($urandom);
      endcase
   endfunction

   initial begin
      int n;
      int phase;
      int pick;
      logic [btmx_pkg::KEY_BITS-1:0] k;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed words: empty trie, extremes, duplicates, clear, spare op.
      send_word(btmx_pkg::OP_QUERY, '0);
      send_word(OP_SPARE, ALL_ONES);
      send_word(btmx_pkg::OP_INSERT, '0);
      send_word(btmx_pkg::OP_QUERY, ALL_ONES);
      send_word(btmx_pkg::OP_QUERY, '0);
      send_word(btmx_pkg::OP_INSERT, ALL_ONES);
      send_word(btmx_pkg::OP_QUERY, '0);
      send_word(btmx_pkg::OP_QUERY, ALL_ONES);
      send_word(btmx_pkg::OP_INSERT, '0);
      send_word(btmx_pkg::OP_INSERT, 30'h2AAA_AAAA);
      send_word(btmx_pkg::OP_INSERT, 30'h1555_5555);
      send_word(btmx_pkg::OP_QUERY, 30'h2AAA_AAAA);
      send_word(btmx_pkg::OP_QUERY, 30'h1555_5555);
      send_word(OP_SPARE, 30'h1555_5555);
      send_word(btmx_pkg::OP_CLEAR, '0);
      send_word(btmx_pkg::OP_QUERY, 30'h1234_5678);
      send_word(btmx_pkg::OP_INSERT, 30'h2000_0000);
      send_word(btmx_pkg::OP_QUERY, '0);
      send_word(btmx_pkg::OP_QUERY, 30'h2000_0000);
      send_word(btmx_pkg::OP_CLEAR, ALL_ONES);
      send_word(btmx_pkg::OP_INSERT, 30'h0000_0001);
      send_word(btmx_pkg::OP_QUERY, 30'h3FFF_FFFE);
      drain_results();

      // Random words under four idling patterns; clears are rare so the
      // trie grows deep between them.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 74; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 74; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         for (n = 0; n < 400; n++) begin
            pick = $urandom_range(199);
            k = pick_key(last_key);
            if (pick < 90) begin
               send_word(btmx_pkg::OP_INSERT, k);
               last_key = k;
            end else if (pick < 191) begin
               send_word(btmx_pkg::OP_QUERY, k);
            end else if (pick == 191) begin
               send_word(btmx_pkg::OP_CLEAR, k);
            end else begin
               send_word(OP_SPARE, k);
            end
         end
         drain_results();
      end

      // Grow the trie with no clears, with some queries mixed in; stop early
      // if an insert is refused.
      idle_pct = 0;
      stall_pct = 24;
      send_word(btmx_pkg::OP_CLEAR, '0);
      n = 0;
      while (full_hits == 0 && n < 400) begin
         k = btmx_pkg::KEY_BITS'($urandom);
         if (n % 8 == 7) begin
            send_word(btmx_pkg::OP_QUERY, k);
         end else begin
            send_word(btmx_pkg::OP_INSERT, k);
            last_key = k;
         end
         n++;
      end
      send_word(btmx_pkg::OP_INSERT, last_key);
      send_word(btmx_pkg::OP_INSERT, btmx_pkg::KEY_BITS'($urandom));
      send_word(btmx_pkg::OP_QUERY, '0);
      send_word(btmx_pkg::OP_QUERY, ALL_ONES);
      drain_results();

      // The trie must be usable again after a clear from a deep state.
      send_word(btmx_pkg::OP_CLEAR, '0);
      send_word(btmx_pkg::OP_QUERY, last_key);
      send_word(btmx_pkg::OP_INSERT, last_key);
      send_word(btmx_pkg::OP_QUERY, ~last_key);
      drain_results();

      repeat (40) @(posedge clock);
      if (fail_count == 0 && words_waiting == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("FAILURE");
      $finish;
   end

endmodule
